// ===== rtl/sequential_servo_pulse_generator_assert.svh =====
// Assertion helpers for the servo pulse generator.
// Every check is clocked on clk_i and held off while rst_ni is low.
`ifndef SEQUENTIAL_SERVO_PULSE_GENERATOR_ASSERT_SVH
`define SEQUENTIAL_SERVO_PULSE_GENERATOR_ASSERT_SVH

// Check a property on every rising edge outside reset
`define SSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define SSP_NEVER(label, cond, msg) \
  `SSP_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/ssp_pkg.sv =====
package ssp_pkg;

  // Fixed field widths
  localparam int NUM_ANGLE_REGS = 6;
  localparam int NUM_OUT        = 6;
  localparam int ANGLE_W        = 8;
  localparam int WIDTH_W        = 12;
  localparam int TIME_W         = 16;
  localparam int SLOT_OUT_W     = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd7;

  // Pulse width arithmetic: 100*angle/9 + 500
  localparam logic [6:0]         ANGLE_SCALE   = 7'd100;
  localparam logic [12:0]        RECIP_9       = 13'd7282;  // ceil(2^16 / 9)
  localparam logic [WIDTH_W-1:0] PULSE_BASE    = 12'd500;
  localparam logic [TIME_W-1:0]  PERIOD_RESET  = 16'd20000;

  typedef struct packed {
    logic [NUM_ANGLE_REGS-1:0][WIDTH_W-1:0] width;
    logic [NUM_OUT-1:0]                     enable;
    logic [TIME_W-1:0]                      period;
  } cfg_t;

  typedef struct packed {
    logic [NUM_OUT-1:0]    pulse;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  frame_start;
  } res_t;

  // Divide by 9 through a reciprocal multiply; exact for products up to 25500
  function automatic logic [WIDTH_W-1:0] pulse_width(input logic [ANGLE_W-1:0] angle);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = 15'(angle) * 15'(ANGLE_SCALE);
    prod   = 28'(scaled) * 28'(RECIP_9);
    return prod[27:16] + PULSE_BASE;
  endfunction

endpackage

// ===== rtl/ssp_cfg_regs.sv =====
module ssp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ssp_pkg::cfg_t                  cfg_o
);
  import ssp_pkg::*;

  cfg_t cfg_q;

  // Store pulse widths already converted from angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ANGLE_REGS; i++) begin
        cfg_q.width[i] <= PULSE_BASE;
      end
      cfg_q.enable <= '0;
      cfg_q.period <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i inside {[REG_ANGLE0:REG_ANGLE5]}) begin
        cfg_q.width[cfg_idx_i] <= pulse_width(cfg_wdata_i[ANGLE_W-1:0]);
      end else begin
        case (cfg_idx_i)
          REG_ENABLE: cfg_q.enable <= cfg_wdata_i[NUM_OUT-1:0];
          REG_PERIOD: cfg_q.period <= cfg_wdata_i[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ssp_slot_seq.sv =====
module ssp_slot_seq #(
  parameter int CHANNELS = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  logic          tick_i,
  input  ssp_pkg::cfg_t cfg_i,
  output ssp_pkg::res_t res_o
);
  import ssp_pkg::*;

  localparam int SLOT_W = $clog2(CHANNELS + 1);
  localparam logic [SLOT_W-1:0] SLOT_IDLE = SLOT_W'(CHANNELS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CHANNELS - 1);

  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [TIME_W-1:0]  cd_q, cd_d;
  logic [TIME_W-1:0]  rem_q, rem_d;
  logic [NUM_OUT-1:0] lvl_q, lvl_d;
  logic               first_q, first_d;

  logic [SLOT_W-1:0]  slot_nxt;
  logic [WIDTH_W-1:0] cur_w, nxt_w;
  logic [TIME_W-1:0]  rem_sat, cd_a;
  logic [3:0]         slot_ext;
  logic               first_a, restart;
  logic               idle_wrap;

  // Width of a channel slot; channels without an angle register use angle 0
  function automatic logic [WIDTH_W-1:0] width_sel(input cfg_t cfg,
                                                   input logic [SLOT_W-1:0] s);
    logic [3:0] s4;
    s4 = 4'(s);
    if (s4 < 4'(NUM_ANGLE_REGS)) return cfg.width[s4[2:0]];
    return PULSE_BASE;
  endfunction

  assign slot_nxt = slot_q + 1'b1;
  assign cur_w    = width_sel(cfg_i, slot_q);
  assign nxt_w    = width_sel(cfg_i, slot_nxt);
  assign rem_sat  = (rem_q > TIME_W'(cur_w)) ? rem_q - TIME_W'(cur_w) : '0;

  // Advance the slot when the countdown has run out, then spend the tick
  always_comb begin
    slot_d  = slot_q;
    rem_d   = rem_q;
    cd_a    = cd_q;
    first_a = first_q;
    restart = 1'b0;
    if (cd_q == '0) begin
      if (slot_q == SLOT_IDLE) begin
        restart = 1'b1;
      end else if (slot_q == SLOT_LAST) begin
        if (rem_sat == '0) begin
          restart = 1'b1;
        end else begin
          slot_d = SLOT_IDLE;
          rem_d  = rem_sat;
          cd_a   = rem_sat;
        end
      end else begin
        slot_d = slot_nxt;
        rem_d  = rem_sat;
        cd_a   = TIME_W'(nxt_w);
      end
    end
    if (restart) begin
      slot_d  = '0;
      rem_d   = cfg_i.period;
      cd_a    = TIME_W'(cfg_i.width[0]);
      first_a = 1'b1;
    end
    cd_d     = (cd_a != '0) ? cd_a - 1'b1 : '0;
    first_d  = 1'b0;
    slot_ext = 4'(slot_d);
    lvl_d    = '0;
    if (slot_ext < 4'(NUM_OUT) && slot_d < SLOT_IDLE && cfg_i.enable[slot_ext[2:0]]) begin
      lvl_d = {{(NUM_OUT-1){1'b0}}, 1'b1} << slot_ext[2:0];
    end
  end

  // Update state only on an accepted tick request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      cd_q    <= TIME_W'(PULSE_BASE);
      rem_q   <= PERIOD_RESET;
      lvl_q   <= '0;
      first_q <= 1'b1;
    end else if (step_en_i && tick_i) begin
      slot_q  <= slot_d;
      cd_q    <= cd_d;
      rem_q   <= rem_d;
      lvl_q   <= lvl_d;
      first_q <= first_d;
    end
  end

  // Build the result; a hold request repeats the current levels and slot
  always_comb begin
    if (tick_i) begin
      res_o.pulse       = lvl_d;
      res_o.slot        = SLOT_OUT_W'(slot_d);
      res_o.frame_start = first_a;
    end else begin
      res_o.pulse       = lvl_q;
      res_o.slot        = SLOT_OUT_W'(slot_q);
      res_o.frame_start = 1'b0;
    end
  end

  // Flag a tick that closes the idle slot
  assign idle_wrap = step_en_i && tick_i && cd_q == '0 && slot_q == SLOT_IDLE;

  `include "sequential_servo_pulse_generator_assert.svh"

  `SSP_ASSERT(a_lvl_onehot, $onehot0(lvl_q), "more than one servo output high")
  `SSP_NEVER(a_slot_range, slot_q > SLOT_IDLE, "slot beyond idle slot")
  `SSP_ASSERT(a_restart_period, idle_wrap |=> slot_q == '0 && rem_q == $past(cfg_i.period), "frame restart did not load the period")

endmodule

// ===== rtl/ssp_out_skid.sv =====
module ssp_out_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ssp_pkg::res_t res_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ssp_pkg::res_t res_o
);
  import ssp_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_res_q, skid_res_q;
  logic out_held, accept;

  assign out_held   = out_valid_q && out_stall_i;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  // Hold control: park a request in the skid stage while the output waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_held) begin
      if (accept) skid_valid_q <= 1'b1;
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept;
    end
  end

  // Move payload alongside the control
  always_ff @(posedge clk_i) begin
    if (out_held) begin
      if (accept) skid_res_q <= res_i;
    end else if (skid_valid_q) begin
      out_res_q <= skid_res_q;
    end else if (accept) begin
      out_res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_res_q;

  `include "sequential_servo_pulse_generator_assert.svh"

  `SSP_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `SSP_ASSERT(a_skid_fill, accept && out_held |=> skid_valid_q, "request lost while output held")
  `SSP_ASSERT(a_skid_drain, skid_valid_q && !out_stall_i |=> out_valid_q && !skid_valid_q, "skid did not drain")

endmodule

// ===== rtl/sequential_servo_pulse_generator.sv =====
// Multiplexed servo pulse generator.
// Input channel (in_valid_i / in_stall_o): one request per microsecond
// tick; tick_i = 1 advances time by one microsecond, 0 only samples the
// current levels. Every accepted request yields exactly one result on the
// output channel (out_valid_o / out_stall_i): pulse_outputs_o, slot_index_o
// and frame_start_o. Slots 0..CHANNELS-1 drive servo k high for
// 100*angle/9+500 us when enabled; slot CHANNELS fills out the frame.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
// the write edge; angles are converted to widths there.
// Throughput: one request per cycle while in_stall_o is low; the slot
// step is one countdown and one subtract between the state registers and
// the output register. Receiver stall: results queue in the output
// register plus one skid entry; in_stall_o rises only when both are
// full. Reset: angles 0, all channels disabled, period 20000 us, slot 0,
// and the next tick opens a frame. No clearing pass is needed.
module sequential_servo_pulse_generator #(
  parameter int CHANNELS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           tick_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ssp_pkg::NUM_OUT-1:0]    pulse_outputs_o,
  output logic [ssp_pkg::SLOT_OUT_W-1:0] slot_index_o,
  output logic                           frame_start_o
);
  import ssp_pkg::*;

  cfg_t cfg;
  res_t step_res, out_res;
  logic step_en;

  assign step_en = in_valid_i && !in_stall_o;

  ssp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssp_slot_seq #(
    .CHANNELS (CHANNELS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .tick_i    (tick_i),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  ssp_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .res_i       (step_res),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign pulse_outputs_o = out_res.pulse;
  assign slot_index_o    = out_res.slot;
  assign frame_start_o   = out_res.frame_start;

endmodule
